>>> hdl/control_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// Control frame receiver assertion macros
// Concurrent assertion wrappers shared by the receiver RTL. Defining
// ASSERT_OFF turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef CONTROL_FRAME_RECEIVER_DEFINES_SVH
`define CONTROL_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside of reset.
`define CFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CFR_ASSERT(lbl, prop, msg)
`define CFR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hdl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// Control frame receiver package
// Field widths, command codes, frame constants and the CRC-16/ARC byte step.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Joystick store geometry.
  localparam int STICKS      = 4;
  localparam int STICK_BYTES = 18;
  localparam int STORE_BYTES = STICKS * STICK_BYTES;
  localparam int IDX_W       = $clog2(STORE_BYTES);
  // Two banks: one holds committed records, the other stages the next frame.
  localparam int RAM_DEPTH   = 2 * STORE_BYTES;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);

  // Field widths.
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int SIDX_W = 3;
  localparam int BIDX_W = 5;
  localparam int CNT_W  = 3;
  localparam int MIN_W  = 8;
  localparam int TO_W   = 10;
  localparam int POS_W  = 10;
  localparam int MS_W   = 11;
  localparam int MSM_W  = 16;
  localparam int CRC_W  = 16;

  // Saturation limits and frame constants.
  localparam logic [POS_W-1:0]  POS_MAX       = 10'd1023;
  localparam logic [MS_W-1:0]   MS_MAX        = 11'd2047;
  localparam logic [MSM_W-1:0]  MS_PER_MINUTE = 16'd60000;
  localparam logic [MIN_W-1:0]  MINUTE_MAX    = 8'd255;
  localparam logic [TO_W-1:0]   TIMEOUT_RESET = 10'd200;
  localparam logic [BYTE_W-1:0] TYPE_HEART    = 8'h68;
  localparam logic [BYTE_W-1:0] TYPE_CONTROL  = 8'h63;
  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  // Result kinds.
  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  // One byte of reflected CRC-16/ARC, least significant bit first.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                               input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/cfr_channels.sv
// ----------------------------------------------------------------------------
// Control frame receiver channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------

// Request channel: one frame byte, tick or joystick read per transfer.
interface cfr_in_if;
  logic                          valid;
  logic                          ready;
  logic [cfr_pkg::CMD_W-1:0]     command;
  logic [cfr_pkg::BYTE_W-1:0]    data_byte;
  logic                          last_byte;
  logic [cfr_pkg::SIDX_W-1:0]    stick_index;
  logic [cfr_pkg::BIDX_W-1:0]    stick_byte_index;

  modport source (
    output valid, command, data_byte, last_byte, stick_index, stick_byte_index,
    input  ready
  );
  modport sink (
    input  valid, command, data_byte, last_byte, stick_index, stick_byte_index,
    output ready
  );
endinterface

// Result channel: frame status or joystick read data.
interface cfr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          frame_ok;
  logic                          enabled;
  logic [cfr_pkg::CNT_W-1:0]     stick_count;
  logic [cfr_pkg::MIN_W-1:0]     uptime_minutes;
  logic                          read_valid;
  logic [cfr_pkg::BYTE_W-1:0]    read_byte;

  modport source (
    output valid, kind, frame_ok, enabled, stick_count, uptime_minutes,
           read_valid, read_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, frame_ok, enabled, stick_count, uptime_minutes,
           read_valid, read_byte,
    output ready
  );
endinterface

>>> hdl/cfr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/control_frame_receiver.sv
// ----------------------------------------------------------------------------
// Control frame receiver
// Checks CRC-16/ARC framed control packets, keeps the enable state, link
// watchdog and uptime, and serves reads of the stored joystick records.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_chan: frame bytes (with last_byte on the final one),
// one-millisecond ticks, and joystick byte reads. Results leave on out_chan:
// a status result at each frame end and a data result for each read; other
// requests give no result. The timeout register is written through cfg_wr_en
// and cfg_wr_data, by the user only while the block is idle; it is not enforced.
// Each request is held in the input register, where all of its work is done,
// and its result is then registered in the output register. One request is
// taken every cycle unless a request with a result waits on a stalled result
// side; that rate is set by the single processing stage and the one read
// port of the joystick RAM.
// Joystick bytes live in a two-bank RAM: the staging bank fills during a
// frame and becomes the committed bank when a valid control frame ends.
// Synchronous reset clears all state and sets the timeout to 200 ms; the RAM
// needs no clearing pass. When the result side stalls, a pending result holds
// in the output register, and the input register still drains requests that
// give no result; a request with a result waits in it.
// ----------------------------------------------------------------------------
`include "control_frame_receiver_defines.svh"

module control_frame_receiver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [cfr_pkg::TO_W-1:0]    cfg_wr_data,
  cfr_in_if.sink                      in_chan,
  cfr_out_if.source                   out_chan
);

  // Input register.
  logic                        s1_valid_r;
  logic [cfr_pkg::CMD_W-1:0]   s1_cmd_r;
  logic [cfr_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                        s1_last_r;
  logic [cfr_pkg::SIDX_W-1:0]  s1_sidx_r;
  logic [cfr_pkg::BIDX_W-1:0]  s1_bidx_r;

  // Output register.
  logic                        out_valid_r;
  logic                        out_kind_r;
  logic                        out_ok_r;
  logic                        out_en_r;
  logic [cfr_pkg::CNT_W-1:0]   out_cnt_r;
  logic [cfr_pkg::MIN_W-1:0]   out_min_r;
  logic                        out_rv_r;

  // Block state and next values.
  logic [cfr_pkg::TO_W-1:0]    timeout_r;
  logic [cfr_pkg::CRC_W-1:0]   crc_r,       crc_nxt;
  logic [cfr_pkg::POS_W-1:0]   pos_r,       pos_nxt;
  logic [cfr_pkg::CRC_W-1:0]   tail_r,      tail_nxt;
  logic [cfr_pkg::BYTE_W-1:0]  type_r,      type_nxt;
  logic                        bank_r,      bank_nxt;
  logic [cfr_pkg::CNT_W-1:0]   held_r,      held_nxt;
  logic                        enable_r,    enable_nxt;
  logic [cfr_pkg::MS_W-1:0]    ms_frame_r,  ms_frame_nxt;
  logic [cfr_pkg::MSM_W-1:0]   ms_min_r,    ms_min_nxt;
  logic [cfr_pkg::MIN_W-1:0]   minute_r,    minute_nxt;

  // Handshake control.
  logic                        s1_emits;
  logic                        out_free;
  logic                        s1_adv;
  logic                        is_byte;
  logic                        is_tick;
  logic                        is_read;

  // Frame byte datapath.
  logic [cfr_pkg::CRC_W-1:0]   crc_fed;
  logic [cfr_pkg::CRC_W-1:0]   tail_new;
  logic [cfr_pkg::POS_W-1:0]   pos_inc;
  logic [cfr_pkg::POS_W-1:0]   stage_off;
  logic                        stage_wr;
  logic [cfr_pkg::BYTE_W-1:0]  type_eff;
  logic                        frame_good;
  logic [cfr_pkg::POS_W-1:0]   payload;
  logic [cfr_pkg::CNT_W-1:0]   sticks_new;
  logic                        commit;

  // Tick datapath.
  logic [cfr_pkg::MS_W-1:0]    ms_inc;
  logic [cfr_pkg::MSM_W-1:0]   ms_min_inc;

  // Read datapath.
  logic                        rd_hit;
  logic [cfr_pkg::IDX_W-1:0]   rd_idx;
  logic                        ram_wr_en;
  logic [cfr_pkg::RAM_AW-1:0]  ram_wr_addr;
  logic                        ram_rd_en;
  logic [cfr_pkg::RAM_AW-1:0]  ram_rd_addr;
  logic [cfr_pkg::BYTE_W-1:0]  ram_rd_data;

  // Request decode and handshake.
  assign is_byte  = (s1_cmd_r == cfr_pkg::CMD_BYTE);
  assign is_tick  = (s1_cmd_r == cfr_pkg::CMD_TICK);
  assign is_read  = (s1_cmd_r == cfr_pkg::CMD_READ);
  assign s1_emits = s1_valid_r && ((is_byte && s1_last_r) || is_read);
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_adv   = s1_valid_r && (!s1_emits || out_free);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  // The byte two places back joins the CRC once the frame has three bytes.
  assign crc_fed  = (pos_r >= cfr_pkg::POS_W'(2)) ?
                    cfr_pkg::crc_feed(crc_r, tail_r[15:8]) : crc_r;
  assign tail_new = {tail_r[7:0], s1_byte_r};
  assign pos_inc  = (pos_r < cfr_pkg::POS_MAX) ? pos_r + 1'b1 : pos_r;
  assign type_eff = (pos_r == '0) ? s1_byte_r : type_r;

  // Payload bytes are staged in the bank that is not committed.
  assign stage_off = pos_r - cfr_pkg::POS_W'(3);
  assign stage_wr  = (pos_r >= cfr_pkg::POS_W'(3)) &&
                     (stage_off < cfr_pkg::POS_W'(cfr_pkg::STORE_BYTES));
  assign ram_wr_en = s1_adv && is_byte && stage_wr;
  assign ram_wr_addr = bank_r ? cfr_pkg::RAM_AW'(stage_off[cfr_pkg::IDX_W-1:0]) :
                       cfr_pkg::RAM_AW'(cfr_pkg::STORE_BYTES) +
                       cfr_pkg::RAM_AW'(stage_off[cfr_pkg::IDX_W-1:0]);

  // Frame end check.
  assign frame_good = (pos_inc >= cfr_pkg::POS_W'(3)) && (crc_fed == tail_new);
  assign payload    = pos_inc - cfr_pkg::POS_W'(3);
  assign commit     = s1_adv && is_byte && s1_last_r && frame_good &&
                      (type_eff == cfr_pkg::TYPE_CONTROL);

  // Whole records in the payload, capped at the store size.
  always_comb begin
    sticks_new = '0;
    for (int k = 1; k <= cfr_pkg::STICKS; k++) begin
      if (payload >= cfr_pkg::POS_W'(k * cfr_pkg::STICK_BYTES)) begin
        sticks_new = cfr_pkg::CNT_W'(k);
      end
    end
  end

  // Tick counters.
  assign ms_inc     = (ms_frame_r < cfr_pkg::MS_MAX) ? ms_frame_r + 1'b1 : ms_frame_r;
  assign ms_min_inc = ms_min_r + 1'b1;

  // Joystick read lookup in the committed bank.
  assign rd_hit = (s1_sidx_r != '0) && (s1_sidx_r <= held_r) &&
                  ({1'b0, s1_sidx_r} <= (cfr_pkg::SIDX_W + 1)'(cfr_pkg::STICKS)) &&
                  ({1'b0, s1_bidx_r} <= (cfr_pkg::BIDX_W + 1)'(cfr_pkg::STICK_BYTES - 1));
  assign rd_idx = cfr_pkg::IDX_W'(s1_sidx_r - 1'b1) *
                  cfr_pkg::IDX_W'(cfr_pkg::STICK_BYTES) +
                  cfr_pkg::IDX_W'(s1_bidx_r);
  assign ram_rd_en   = s1_adv && is_read && rd_hit;
  assign ram_rd_addr = bank_r ? cfr_pkg::RAM_AW'(cfr_pkg::STORE_BYTES) +
                       cfr_pkg::RAM_AW'(rd_idx) : cfr_pkg::RAM_AW'(rd_idx);

  // Next state for the request in the input register.
  always_comb begin
    crc_nxt      = crc_r;
    pos_nxt      = pos_r;
    tail_nxt     = tail_r;
    type_nxt     = type_r;
    bank_nxt     = bank_r;
    held_nxt     = held_r;
    enable_nxt   = enable_r;
    ms_frame_nxt = ms_frame_r;
    ms_min_nxt   = ms_min_r;
    minute_nxt   = minute_r;
    if (s1_adv) begin
      case (s1_cmd_r)
        cfr_pkg::CMD_BYTE: begin
          type_nxt = type_eff;
          if (s1_last_r) begin
            crc_nxt  = '0;
            pos_nxt  = '0;
            tail_nxt = '0;
            if (frame_good && (type_eff == cfr_pkg::TYPE_HEART)) begin
              enable_nxt   = 1'b0;
              ms_frame_nxt = '0;
            end
            if (commit) begin
              enable_nxt   = 1'b1;
              ms_frame_nxt = '0;
              held_nxt     = sticks_new;
              bank_nxt     = !bank_r;
            end
          end else begin
            crc_nxt  = crc_fed;
            pos_nxt  = pos_inc;
            tail_nxt = tail_new;
          end
        end
        cfr_pkg::CMD_TICK: begin
          ms_frame_nxt = ms_inc;
          if (ms_inc > {1'b0, timeout_r}) begin
            enable_nxt = 1'b0;
          end
          if (ms_min_inc >= cfr_pkg::MS_PER_MINUTE) begin
            ms_min_nxt = '0;
            if (minute_r < cfr_pkg::MINUTE_MAX) begin
              minute_nxt = minute_r + 1'b1;
            end
          end else begin
            ms_min_nxt = ms_min_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= cfr_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= '0;
      pos_r      <= '0;
      tail_r     <= '0;
      type_r     <= '0;
      bank_r     <= 1'b0;
      held_r     <= '0;
      enable_r   <= 1'b0;
      ms_frame_r <= '0;
      ms_min_r   <= '0;
      minute_r   <= '0;
    end else begin
      crc_r      <= crc_nxt;
      pos_r      <= pos_nxt;
      tail_r     <= tail_nxt;
      type_r     <= type_nxt;
      bank_r     <= bank_nxt;
      held_r     <= held_nxt;
      enable_r   <= enable_nxt;
      ms_frame_r <= ms_frame_nxt;
      ms_min_r   <= ms_min_nxt;
      minute_r   <= minute_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_cmd_r  <= in_chan.command;
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
      s1_sidx_r <= in_chan.stick_index;
      s1_bidx_r <= in_chan.stick_byte_index;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_emits;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emits) begin
      out_kind_r <= is_read ? cfr_pkg::KIND_READ : cfr_pkg::KIND_STATUS;
      out_ok_r   <= is_byte && frame_good;
      out_en_r   <= enable_nxt;
      out_cnt_r  <= held_nxt;
      out_min_r  <= minute_nxt;
      out_rv_r   <= ram_rd_en;
    end
  end

  // Two-bank joystick store.
  cfr_ram #(
    .WIDTH (cfr_pkg::BYTE_W),
    .DEPTH (cfr_pkg::RAM_DEPTH)
  ) u_stick_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (tail_r[15:8]),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result channel.
  assign out_chan.valid          = out_valid_r;
  assign out_chan.kind           = out_kind_r;
  assign out_chan.frame_ok       = out_ok_r;
  assign out_chan.enabled        = out_en_r;
  assign out_chan.stick_count    = out_cnt_r;
  assign out_chan.uptime_minutes = out_min_r;
  assign out_chan.read_valid     = out_rv_r;
  assign out_chan.read_byte      = out_rv_r ? ram_rd_data : '0;

  // Assertions.
  `CFR_ASSERT(a_rd_only_when_free, ram_rd_en |-> out_free, "RAM read while result stalled")
  `CFR_ASSERT(a_bank_flip_on_commit, !$stable(bank_r) |-> $past(commit), "bank flip without commit")
  `CFR_ASSERT(a_crc_idle_early, (pos_r <= cfr_pkg::POS_W'(2)) |-> (crc_r == '0), "CRC fed too early")
  `CFR_ASSERT(a_read_kind, (out_valid_r && out_rv_r) |-> (out_kind_r == cfr_pkg::KIND_READ), "read data on status result")
  `CFR_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid_r && !s1_valid_r), "reset left a request in flight")

endmodule

>>> tb/sv/control_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// Control frame receiver testbench
// Sends frame bytes, millisecond ticks, joystick reads and spare commands
// through the request channel. A bit-accurate mirror of the receiver state
// computes the status and read data that each request should return, and
// every result taken from the result channel is compared field by field
// against the oldest outstanding reply. Both channels stall at random, and
// the link timeout is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module control_frame_receiver_tb;
  import cfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned IDLE_PCT    = 19;
  localparam int unsigned SETTLE_CYC  = 6;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // One request as the sender holds it.
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [SIDX_W-1:0] sidx;
    logic [BIDX_W-1:0] bidx;
    bit                drain;
  } request_t;

  // One result as the block should return it.
  typedef struct {
    kind_t             kind;
    logic              frame_ok;
    logic              enabled;
    logic [CNT_W-1:0]  stick_count;
    logic [MIN_W-1:0]  uptime;
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [TO_W-1:0] cfg_wr_data;

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();

  control_frame_receiver dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_ch),
    .out_chan    (out_ch)
  );

  always #6 clk = ~clk;

  request_t    pending [$];
  reply_t      replies_due [$];
  request_t    next_req;
  reply_t      oldest;
  int unsigned queued;
  int unsigned mismatches;
  int unsigned cycles;
  bit          calm;
  bit          drain_next;

  // Mirror of the receiver state.
  logic [TO_W-1:0]   link_timeout = TIMEOUT_RESET;
  logic [CRC_W-1:0]  link_crc     = '0;
  logic [POS_W-1:0]  link_pos     = '0;
  logic [CRC_W-1:0]  link_tail    = '0;
  logic [BYTE_W-1:0] link_type    = '0;
  logic [BYTE_W-1:0] link_staged [STORE_BYTES] = '{default: 8'h00};
  logic [BYTE_W-1:0] link_store  [STORE_BYTES] = '{default: 8'h00};
  logic [CNT_W-1:0]  link_sticks  = '0;
  logic              link_enabled = 1'b0;
  logic [MS_W-1:0]   link_idle_ms = '0;
  logic [MSM_W-1:0]  link_ms      = '0;
  logic [MIN_W-1:0]  link_minutes = '0;

  // Reflected CRC-16/ARC over one byte.
  function automatic logic [CRC_W-1:0] arc_step(input logic [CRC_W-1:0] acc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = acc ^ {8'h00, b};
    repeat (BYTE_W) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Advance the mirror by one accepted request and record any reply it owes.
  task automatic absorb_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                                input logic last, input logic [SIDX_W-1:0] sidx,
                                input logic [BIDX_W-1:0] bidx);
    logic [BYTE_W-1:0] spill;
    logic              ok;
    int                slot;
    int                payload;
    int                quota;
    int                i;
    case (cmd)
      CMD_BYTE: begin
        if (link_pos == 0) link_type = data;
        if (link_pos >= 2) begin
          spill = link_tail[15:8];
          link_crc = arc_step(link_crc, spill);
          slot = int'(link_pos) - 3;
          if (slot >= 0 && slot < STORE_BYTES) link_staged[slot] = spill;
        end
        link_tail = {link_tail[7:0], data};
        if (link_pos < POS_MAX) link_pos = link_pos + 1'b1;
        if (last) begin
          ok = (link_pos >= 3) && (link_crc == link_tail);
          if (ok && link_type == TYPE_HEART) begin
            link_enabled = 1'b0;
            link_idle_ms = '0;
          end else if (ok && link_type == TYPE_CONTROL) begin
            payload = int'(link_pos) - 3;
            quota = payload / STICK_BYTES;
            link_enabled = 1'b1;
            link_idle_ms = '0;
            link_sticks = (quota > STICKS) ? STICKS : quota;
            for (i = 0; i < STORE_BYTES && i < payload; i++) link_store[i] = link_staged[i];
          end
          link_crc = '0;
          link_pos = '0;
          link_tail = '0;
          replies_due.push_back('{KIND_STATUS, ok, link_enabled, link_sticks, link_minutes,
                                  1'b0, 8'h00});
        end
      end
      CMD_TICK: begin
        if (link_idle_ms < MS_MAX) link_idle_ms = link_idle_ms + 1'b1;
        if (link_idle_ms > link_timeout) link_enabled = 1'b0;
        link_ms = link_ms + 1'b1;
        if (link_ms >= MS_PER_MINUTE) begin
          link_ms = '0;
          if (link_minutes < MINUTE_MAX) link_minutes = link_minutes + 1'b1;
        end
      end
      CMD_READ: begin
        if (sidx >= 1 && sidx <= link_sticks && sidx <= STICKS && bidx < STICK_BYTES) begin
          slot = (int'(sidx) - 1) * STICK_BYTES + int'(bidx);
          replies_due.push_back('{KIND_READ, 1'b0, link_enabled, link_sticks, link_minutes,
                                  1'b1, link_store[slot]});
        end else begin
          replies_due.push_back('{KIND_READ, 1'b0, link_enabled, link_sticks, link_minutes,
                                  1'b0, 8'h00});
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                               input logic last, input logic [SIDX_W-1:0] sidx,
                               input logic [BIDX_W-1:0] bidx);
    pending.push_back('{cmd, data, last, sidx, bidx, drain_next});
    drain_next = 1'b0;
    queued++;
  endtask

  // A frame: lead byte, random payload, big-endian CRC, optionally one bit hit.
  task automatic queue_frame(input logic [BYTE_W-1:0] lead, input int unsigned body,
                             input bit damaged);
    logic [BYTE_W-1:0] bytes [$];
    logic [CRC_W-1:0]  sum;
    int unsigned       hit;
    bytes.push_back(lead);
    repeat (body) bytes.push_back($urandom_range(255));
    sum = '0;
    foreach (bytes[i]) sum = arc_step(sum, bytes[i]);
    bytes.push_back(sum[15:8]);
    bytes.push_back(sum[7:0]);
    if (damaged) begin
      hit = $urandom_range(bytes.size() - 1);
      bytes[hit] = bytes[hit] ^ (8'h01 << $urandom_range(7));
    end
    foreach (bytes[i]) begin
      queue_request(CMD_BYTE, bytes[i], i == bytes.size() - 1, $urandom_range(7),
                    $urandom_range(31));
    end
  endtask

  // Random traffic: mostly well-formed frames and reads, with ticks and noise.
  task automatic queue_mixed(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned body;
    int          n;
    logic [BYTE_W-1:0] lead;
    start = queued;
    while (queued - start < budget) begin
      if ($urandom_range(99) < 3) drain_next = 1'b1;
      pick = $urandom_range(99);
      body = ($urandom_range(99) < 6) ? $urandom_range(91, 200) : $urandom_range(0, 90);
      lead = $urandom_range(255);
      if (lead == TYPE_CONTROL || lead == TYPE_HEART) lead = lead ^ 8'h01;
      if (pick < 32) begin
        queue_frame(TYPE_CONTROL, body, 1'b0);
      end else if (pick < 38) begin
        queue_frame(TYPE_HEART, $urandom_range(0, 20), 1'b0);
      end else if (pick < 43) begin
        queue_frame(lead, $urandom_range(0, 40), 1'b0);
      end else if (pick < 52) begin
        case ($urandom_range(2))
          0: queue_frame(TYPE_CONTROL, body, 1'b1);
          1: queue_frame(TYPE_HEART, $urandom_range(0, 20), 1'b1);
          default: queue_frame(lead, $urandom_range(0, 20), 1'b1);
        endcase
      end else if (pick < 56) begin
        // Frame too short to carry a CRC.
        n = $urandom_range(1, 2);
        for (int k = 0; k < n; k++) begin
          queue_request(CMD_BYTE, $urandom_range(255), k == n - 1, $urandom_range(7),
                        $urandom_range(31));
        end
      end else if (pick < 72) begin
        // Tick burst, sometimes sized to straddle the link timeout.
        n = $urandom_range(1, 20);
        if ($urandom_range(99) < 20) n = int'(link_timeout) + $urandom_range(2) - 1;
        if (n < 1) n = 1;
        repeat (n) begin
          queue_request(CMD_TICK, $urandom_range(255), $urandom_range(1), $urandom_range(7),
                        $urandom_range(31));
        end
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(99) < 70) begin
            queue_request(CMD_READ, $urandom_range(255), $urandom_range(1),
                          $urandom_range(1, STICKS), $urandom_range(0, STICK_BYTES - 1));
          end else begin
            queue_request(CMD_READ, $urandom_range(255), $urandom_range(1),
                          $urandom_range(7), $urandom_range(31));
          end
        end
      end else begin
        queue_request(CMD_SPARE, $urandom_range(255), $urandom_range(1), $urandom_range(7),
                      $urandom_range(31));
      end
    end
  endtask

  // Wait until every request has gone in and every reply has come back.
  task automatic wait_for_quiet();
    do @(negedge clk);
    while (pending.size() != 0 || in_ch.valid || replies_due.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [TO_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    link_timeout = value;
    @(negedge clk);
  endtask

  // Request driver: one request per handshake, with random gaps and the
  // occasional pause until all replies are back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending.size() != 0 && !(!calm && $urandom_range(99) < IDLE_PCT) &&
          !(pending[0].drain && (in_ch.valid || replies_due.size() != 0))) begin
        next_req = pending.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.command          <= next_req.cmd;
        in_ch.data_byte        <= next_req.data;
        in_ch.last_byte        <= next_req.last;
        in_ch.stick_index      <= next_req.sidx;
        in_ch.stick_byte_index <= next_req.bidx;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: mirror each accepted request, then check each accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_request(in_ch.command, in_ch.data_byte, in_ch.last_byte, in_ch.stick_index,
                       in_ch.stick_byte_index);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          $error("result returned with no reply outstanding");
          mismatches++;
        end else begin
          oldest = replies_due.pop_front();
          compare_field("kind", oldest.kind, out_ch.kind);
          compare_field("frame_ok", oldest.frame_ok, out_ch.frame_ok);
          compare_field("enabled", oldest.enabled, out_ch.enabled);
          compare_field("stick_count", oldest.stick_count, out_ch.stick_count);
          compare_field("uptime_minutes", oldest.uptime, out_ch.uptime_minutes);
          compare_field("read_valid", oldest.read_valid, out_ch.read_valid);
          compare_field("read_byte", oldest.read_byte, out_ch.read_byte);
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("control_frame_receiver regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    in_ch.valid            = 1'b0;
    in_ch.command          = '0;
    in_ch.data_byte        = '0;
    in_ch.last_byte        = 1'b0;
    in_ch.stick_index      = '0;
    in_ch.stick_byte_index = '0;
    out_ch.ready           = 1'b0;
    queued                 = 0;
    mismatches             = 0;
    cycles                 = 0;
    calm                   = 1'b0;
    drain_next             = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: reads with nothing held, field extremes, spare
    // command, short frames, one valid frame of each type, a bad CRC.
    queue_request(CMD_READ, 8'h00, 1'b0, 3'd1, 5'd0);
    queue_request(CMD_READ, 8'hFF, 1'b1, 3'd7, 5'd31);
    queue_request(CMD_SPARE, 8'hFF, 1'b1, 3'd7, 5'd31);
    queue_request(CMD_BYTE, TYPE_CONTROL, 1'b1, 3'd0, 5'd0);
    queue_request(CMD_BYTE, 8'h00, 1'b0, 3'd0, 5'd0);
    queue_request(CMD_BYTE, 8'h00, 1'b1, 3'd0, 5'd0);
    queue_frame(TYPE_CONTROL, 0, 1'b0);
    queue_frame(8'hFF, 0, 1'b0);
    queue_frame(TYPE_HEART, 0, 1'b0);
    queue_frame(TYPE_CONTROL, 0, 1'b1);
    queue_request(CMD_TICK, 8'h00, 1'b0, 3'd0, 5'd0);
    queue_request(CMD_READ, 8'h00, 1'b0, 3'd0, 5'd17);
    wait_for_quiet();

    // Reset timeout, with one forced pause of the sender behind a read.
    queue_mixed(150);
    queue_request(CMD_READ, 8'h00, 1'b0, 3'd1, 5'd0);
    drain_next = 1'b1;
    queue_mixed(150);
    wait_for_quiet();

    write_timeout(10'd0);
    queue_mixed(260);
    wait_for_quiet();

    write_timeout(10'd1);
    queue_mixed(260);
    wait_for_quiet();

    write_timeout(10'd1000);
    queue_mixed(260);
    wait_for_quiet();

    // An over-long control frame, then a full minute of ticks with no idling.
    calm = 1'b1;
    queue_frame(TYPE_CONTROL, 1027, 1'b0);
    queue_request(CMD_READ, 8'h00, 1'b0, 3'd4, 5'd17);
    repeat (int'(MS_PER_MINUTE)) queue_request(CMD_TICK, 8'h00, 1'b0, 3'd0, 5'd0);
    queue_frame(TYPE_HEART, 0, 1'b0);
    queue_request(CMD_READ, 8'h00, 1'b0, 3'd2, 5'd5);
    wait_for_quiet();
    calm = 1'b0;

    write_timeout($urandom_range(2, 999));
    queue_mixed(260);
    wait_for_quiet();

    write_timeout($urandom_range(1, 1000));
    queue_mixed(260);
    wait_for_quiet();

    if (mismatches == 0) begin
      $display("control_frame_receiver regression: pass");
    end else begin
      $display("control_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule

>>> control_frame_receiver.f
+incdir+hdl
hdl/cfr_pkg.sv
hdl/cfr_channels.sv
hdl/cfr_ram.sv
hdl/control_frame_receiver.sv
tb/sv/control_frame_receiver_tb.sv
